>>> hdl/assert_macros.svh
// Assertion macros for the oscillator stepper.
// Included by the top level; needs clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CHK_SAME(lbl, ante, cons, msg)
`define CHK_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> hdl/osc_pkg.sv
// Shared constants, register map and helpers for the oscillator stepper.
// No dependencies.
package osc_pkg;

  localparam int FRAC_BITS    = 24;
  localparam int CORDIC_ITERS = 24;
  localparam int NITER        = (CORDIC_ITERS < 30) ? CORDIC_ITERS : 30;
  localparam int CSH          = 30 - FRAC_BITS;
  localparam int CNT_W        = 5;

  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint GAIN_Q30    = 64'sd652032874;
  localparam longint PI_Q        = (PI_Q30 + (longint'(1) << (CSH - 1))) >>> CSH;
  localparam longint TWO_PI_Q    = 2 * PI_Q;
  localparam int     RED_BITS    = $clog2((longint'(1) << 31) / TWO_PI_Q + 2) + 1;
  localparam longint RED_OFF     = TWO_PI_Q << (RED_BITS - 1);

  typedef enum logic [2:0] {
    REG_MODEL, REG_METHOD, REG_STIFF, REG_DAMP,
    REG_FORCE, REG_PHSTEP, REG_DT, REG_SAMPLE
  } reg_idx_t;

  // atan(2^-i) in Q30, truncated
  function automatic logic signed [33:0] atan_q30(input logic [CNT_W-1:0] i);
    logic signed [33:0] r;
    case (i)
      5'd0:  r = 34'sd843314856;
      5'd1:  r = 34'sd497837829;
      5'd2:  r = 34'sd263043836;
      5'd3:  r = 34'sd133525158;
      5'd4:  r = 34'sd67021686;
      5'd5:  r = 34'sd33543515;
      5'd6:  r = 34'sd16775850;
      5'd7:  r = 34'sd8388437;
      5'd8:  r = 34'sd4194282;
      5'd9:  r = 34'sd2097149;
      5'd10: r = 34'sd1048575;
      5'd11: r = 34'sd524287;
      5'd12: r = 34'sd262143;
      5'd13: r = 34'sd131071;
      5'd14: r = 34'sd65535;
      5'd15: r = 34'sd32767;
      5'd16: r = 34'sd16383;
      5'd17: r = 34'sd8191;
      5'd18: r = 34'sd4095;
      5'd19: r = 34'sd2047;
      5'd20: r = 34'sd1023;
      5'd21: r = 34'sd511;
      5'd22: r = 34'sd255;
      5'd23: r = 34'sd127;
      5'd24: r = 34'sd63;
      5'd25: r = 34'sd31;
      5'd26: r = 34'sd15;
      5'd27: r = 34'sd7;
      5'd28: r = 34'sd3;
      5'd29: r = 34'sd1;
      default: r = 34'sd0;
    endcase
    return r;
  endfunction

  function automatic logic ovf32(input logic signed [47:0] v);
    return (v > 48'sd2147483647) || (v < -48'sd2147483648);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sd2147483647) r = 32'sh7fffffff;
    else if (v < -48'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

>>> hdl/oscillator_ode_stepper.sv
// Oscillator ODE stepper: one Euler/Heun step per step word, shared multiplier + CORDIC.
// A sample word is registered in the cycle after its input word; a step keeps the block
// busy (Euler/linear model least, Heun/sine model most: 6 angle-reduction steps and 24
// CORDIC iterations per sine evaluation); no input word is taken until it is done.
// Reset (rst_n, synchronous): registers to defaults, state zero, output empty.
// Depends on osc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module oscillator_ode_stepper (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // start_pos[31:0], start_vel[63:32]
  input  logic        in_tuser,   // cmd: 0 step, 1 load
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // sample_pos[31:0], sample_vel[63:32], sample_step[95:64]
  output logic        out_tuser,  // saturated
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import osc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_EV, S_RED_INIT, S_RED, S_COR_INIT, S_COR, S_TRIG,
    S_MK, S_MK_ACC, S_MB, S_MB_ACC, S_PH, S_PH_Z, S_MS, S_MS_ACC,
    S_MF, S_MF_ACC, S_ASAT, S_MX, S_MX_ACC, S_MV, S_MV_ACC,
    S_HX, S_HX_ACC, S_HV, S_HV_ACC
  } state_t;

  // configuration
  logic [1:0]  model_r;
  logic        method_r;
  logic [30:0] stiff_r, damp_r, dt_r;
  logic [31:0] force_r, phstep_r;
  logic [15:0] severy_r;

  // integrator state
  logic signed [31:0] pos_r, vel_r;
  logic [31:0] phase_r, idx_r;
  logic [15:0] scount_r;
  logic        flag_r;

  // sequencer / datapath
  state_t state_r;
  logic   stage_r, neg_r, cosm_r;
  logic [CNT_W-1:0] cnt_r;
  logic [33:0] red_r;
  logic signed [33:0] cz_r, cx_r, cy_r, trig_r;
  logic signed [67:0] prod_r;
  logic signed [47:0] acc_r;
  logic signed [31:0] ex_r, ev_r, a1_r, a2_r, mx_r, mv_r, nx_r;
  logic [31:0] eph_r;

  logic        out_valid_r, out_sat_r;
  logic [95:0] out_data_r;

  logic cfg_wr, in_acc, emit_w;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_acc = in_tvalid && in_tready;
  // a sample word gets loaded this cycle
  assign emit_w = in_acc && (in_tuser || (scount_r >= severy_r));
  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
  assign out_tuser = out_sat_r;

  always_comb begin
    case (reg_idx_t'(cfg_paddr[4:2]))
      REG_MODEL:  cfg_prdata = {30'd0, model_r};
      REG_METHOD: cfg_prdata = {31'd0, method_r};
      REG_STIFF:  cfg_prdata = {1'b0, stiff_r};
      REG_DAMP:   cfg_prdata = {1'b0, damp_r};
      REG_FORCE:  cfg_prdata = force_r;
      REG_PHSTEP: cfg_prdata = phstep_r;
      REG_DT:     cfg_prdata = {1'b0, dt_r};
      REG_SAMPLE: cfg_prdata = {16'd0, severy_r};
      default:    cfg_prdata = 32'd0;
    endcase
  end

  // shared multiplier operand select
  logic signed [33:0] mul_a, mul_b, dt_s;
  assign dt_s = $signed({3'b000, dt_r});
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_MK: begin mul_a = 34'(ex_r);  mul_b = $signed({3'b000, stiff_r}); end
      S_MB: begin mul_a = 34'(ev_r);  mul_b = $signed({3'b000, damp_r}); end
      S_PH: begin mul_a = 34'($signed(eph_r)); mul_b = 34'(PI_Q30); end
      S_MS: begin mul_a = trig_r;     mul_b = $signed({3'b000, stiff_r}); end
      S_MF: begin mul_a = trig_r;     mul_b = 34'($signed(force_r)); end
      S_MX: begin mul_a = 34'(vel_r); mul_b = dt_s; end
      S_MV: begin mul_a = 34'(a1_r);  mul_b = dt_s; end
      S_HX: begin mul_a = 34'(vel_r) + 34'(mv_r); mul_b = dt_s; end
      S_HV: begin mul_a = 34'(a1_r) + 34'(a2_r);  mul_b = dt_s; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // round-to-nearest (ties up) of the registered product
  logic signed [67:0] rf_w, rh_w, rp_w;
  logic signed [47:0] r_frac, r_half;
  always_comb begin
    rf_w = (prod_r + (68'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    rh_w = (prod_r + (68'sd1 <<< FRAC_BITS)) >>> (FRAC_BITS + 1);
    rp_w = (prod_r + (68'sd1 <<< 30)) >>> 31;
    r_frac = 48'(rf_w);
    r_half = 48'(rh_w);
  end

  // CORDIC step, reduction step, trig rounding
  logic signed [33:0] dx, dy, tsrc, tr_w;
  logic [33:0] red_sub, red_nx;
  logic signed [33:0] red_z;
  logic signed [47:0] sum_a, pos_sum, vel_sum, hx_sum, hv_sum;
  always_comb begin
    dx = cy_r >>> cnt_r;
    dy = cx_r >>> cnt_r;
    tsrc = cosm_r ? (neg_r ? -cx_r : cx_r) : cy_r;
    tr_w = (tsrc + (34'sd1 <<< (CSH - 1))) >>> CSH;
    red_sub = 34'(TWO_PI_Q) << cnt_r;
    red_nx = (red_r >= red_sub) ? red_r - red_sub : red_r;
    red_z = ($signed(red_nx) - 34'(PI_Q)) <<< CSH;
    sum_a = acc_r;
    pos_sum = 48'(pos_r) + r_frac;
    vel_sum = 48'(vel_r) + r_frac;
    hx_sum = 48'(pos_r) + r_half;
    hv_sum = 48'(vel_r) + r_half;
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (!rst_n) begin
      model_r <= 2'd2; method_r <= 1'b1;
      stiff_r <= 31'd16777216; damp_r <= 31'd1677722;
      force_r <= 32'd33554432; phstep_r <= 32'd888634;
      dt_r <= 31'd16777; severy_r <= 16'd50;
      pos_r <= '0; vel_r <= '0; phase_r <= '0; idx_r <= '0;
      scount_r <= '0; flag_r <= 1'b0;
      state_r <= S_IDLE; stage_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (reg_idx_t'(cfg_paddr[4:2]))
          REG_MODEL:  model_r  <= cfg_pwdata[1:0];
          REG_METHOD: method_r <= cfg_pwdata[0];
          REG_STIFF:  stiff_r  <= cfg_pwdata[30:0];
          REG_DAMP:   damp_r   <= cfg_pwdata[30:0];
          REG_FORCE:  force_r  <= cfg_pwdata;
          REG_PHSTEP: phstep_r <= cfg_pwdata;
          REG_DT:     dt_r     <= cfg_pwdata[30:0];
          REG_SAMPLE: severy_r <= cfg_pwdata[15:0];
          default: ;
        endcase
      end
      if (out_valid_r && out_tready && !emit_w) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_tuser) begin
              // load: new start state, sample 0 goes out at once
              pos_r <= in_tdata[31:0];
              vel_r <= in_tdata[63:32];
              phase_r <= '0; idx_r <= '0; scount_r <= '0; flag_r <= 1'b0;
              out_data_r <= {32'd0, in_tdata};
              out_sat_r <= 1'b0;
              out_valid_r <= 1'b1;
            end else begin
              // step: pre-step sample when the interval is reached
              if (scount_r >= severy_r) begin
                out_data_r <= {idx_r, vel_r, pos_r};
                out_sat_r <= flag_r;
                out_valid_r <= 1'b1;
                scount_r <= '0;
              end
              ex_r <= pos_r; ev_r <= vel_r; eph_r <= phase_r;
              stage_r <= 1'b0;
              state_r <= S_EV;
            end
          end
        end
        S_EV: state_r <= (model_r == 2'd0) ? S_RED_INIT : S_MK;
        S_RED_INIT: begin
          red_r <= 34'($signed(ex_r)) + 34'(PI_Q) + 34'(RED_OFF);
          cnt_r <= CNT_W'(RED_BITS - 1);
          state_r <= S_RED;
        end
        S_RED: begin
          red_r <= red_nx;
          if (cnt_r == '0) begin
            cz_r <= red_z;
            cosm_r <= 1'b0;
            state_r <= S_COR_INIT;
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        S_COR_INIT: begin
          // fold into [-pi/2, pi/2]; cosine changes sign
          if (cz_r > 34'(HALF_PI_Q30)) begin
            cz_r <= 34'(PI_Q30) - cz_r; neg_r <= 1'b1;
          end else if (cz_r < -34'(HALF_PI_Q30)) begin
            cz_r <= -34'(PI_Q30) - cz_r; neg_r <= 1'b1;
          end else begin
            neg_r <= 1'b0;
          end
          cx_r <= 34'(GAIN_Q30); cy_r <= '0; cnt_r <= '0;
          state_r <= S_COR;
        end
        S_COR: begin
          if (cz_r >= 0) begin
            cx_r <= cx_r - dx; cy_r <= cy_r + dy; cz_r <= cz_r - atan_q30(cnt_r);
          end else begin
            cx_r <= cx_r + dx; cy_r <= cy_r - dy; cz_r <= cz_r + atan_q30(cnt_r);
          end
          if (cnt_r == CNT_W'(NITER - 1)) state_r <= S_TRIG;
          else cnt_r <= cnt_r + 1'b1;
        end
        S_TRIG: begin
          trig_r <= tr_w;
          state_r <= cosm_r ? S_MF : S_MS;
        end
        S_MS: state_r <= S_MS_ACC;
        S_MS_ACC: begin acc_r <= -r_frac; state_r <= S_ASAT; end
        S_MK: state_r <= S_MK_ACC;
        S_MK_ACC: begin acc_r <= -r_frac; state_r <= S_MB; end
        S_MB: state_r <= S_MB_ACC;
        S_MB_ACC: begin
          acc_r <= acc_r - r_frac;
          state_r <= model_r[1] ? S_PH : S_ASAT;
        end
        S_PH: state_r <= S_PH_Z;
        S_PH_Z: begin
          cz_r <= 34'(rp_w);
          cosm_r <= 1'b1;
          state_r <= S_COR_INIT;
        end
        S_MF: state_r <= S_MF_ACC;
        S_MF_ACC: begin acc_r <= acc_r + r_frac; state_r <= S_ASAT; end
        S_ASAT: begin
          flag_r <= flag_r | ovf32(sum_a);
          if (!stage_r) begin a1_r <= sat32(sum_a); state_r <= S_MX; end
          else begin a2_r <= sat32(sum_a); state_r <= S_HX; end
        end
        S_MX: state_r <= S_MX_ACC;
        S_MX_ACC: begin
          mx_r <= sat32(pos_sum);
          flag_r <= flag_r | ovf32(pos_sum);
          state_r <= S_MV;
        end
        S_MV: state_r <= S_MV_ACC;
        S_MV_ACC: begin
          flag_r <= flag_r | ovf32(vel_sum);
          if (!method_r) begin
            pos_r <= mx_r; vel_r <= sat32(vel_sum);
            phase_r <= phase_r + phstep_r;
            scount_r <= scount_r + 1'b1; idx_r <= idx_r + 1'b1;
            state_r <= S_IDLE;
          end else begin
            // second evaluation at the Euler end point
            mv_r <= sat32(vel_sum);
            ex_r <= mx_r; ev_r <= sat32(vel_sum);
            eph_r <= phase_r + phstep_r;
            stage_r <= 1'b1;
            state_r <= S_EV;
          end
        end
        S_HX: state_r <= S_HX_ACC;
        S_HX_ACC: begin
          nx_r <= sat32(hx_sum);
          flag_r <= flag_r | ovf32(hx_sum);
          state_r <= S_HV;
        end
        S_HV: state_r <= S_HV_ACC;
        S_HV_ACC: begin
          flag_r <= flag_r | ovf32(hv_sum);
          pos_r <= nx_r; vel_r <= sat32(hv_sum);
          phase_r <= phase_r + phstep_r;
          scount_r <= scount_r + 1'b1; idx_r <= idx_r + 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `CHK_SAME(a_busy_blocks_input, state_r != S_IDLE, !in_tready, "input taken mid-step")
  `CHK_NEXT(a_load_sets_pos, in_tvalid && in_tready && in_tuser, pos_r == $past(in_tdata[31:0]), "load lost")
  `CHK_NEXT(a_no_spurious_out, !out_valid_r && !(in_tvalid && in_tready), !out_valid_r, "word from nowhere")

endmodule
